// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level of the arc bounding box unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("%m: invariant violated");

// When the antecedent holds, the consequent must hold at the same edge.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication violated");

// When the antecedent holds, the consequent must hold at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check violated");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/acbb_pkg.sv =====
// Types, constants and helper functions of the arc bounding box unit.
package acbb_pkg;

	// Field and internal widths.
	localparam int IN_W    = 16;
	localparam int OUT_W   = 18;
	localparam int COORD_W = IN_W + 1;
	localparam int SQ_W    = 2 * IN_W;
	localparam int ROOT_W  = IN_W + 1;

	// The square root of a SQ_W-bit value takes one step per result bit.
	localparam int SQRT_STEPS           = SQ_W / 2;
	localparam int SQRT_STEPS_PER_STAGE = 4;
	localparam int SQRT_STAGES          = SQRT_STEPS / SQRT_STEPS_PER_STAGE;

	// Quadrant codes; none is used for a point at the centre.
	typedef logic [2:0] quad_t;
	localparam quad_t QUAD_NONE = 3'd0;
	localparam quad_t QUAD_NE   = 3'd1;
	localparam quad_t QUAD_NW   = 3'd2;
	localparam quad_t QUAD_SW   = 3'd3;
	localparam quad_t QUAD_SE   = 3'd4;

	// Partial remainder and root of the digit-by-digit square root.
	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [SQ_W-1:0] root;
	} sqrt_state_t;

	// Axis extremes that the arc sweeps through.
	typedef struct packed {
		logic north;
		logic west;
		logic south;
		logic east;
	} ext_t;

	// Per-item data that travels alongside the square root.
	typedef struct packed {
		logic signed [COORD_W-1:0] xc;
		logic signed [COORD_W:0]   yc;
		logic signed [COORD_W-1:0] xmin;
		logic signed [COORD_W-1:0] xmax;
		logic signed [COORD_W-1:0] ymin;
		logic signed [COORD_W-1:0] ymax;
		ext_t                      ext;
	} side_t;

	// Quadrant of a point relative to the centre, axes assigned counter-clockwise.
	function automatic quad_t quad_of(logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y);
		quad_t q;
		if (x >= 0 && y > 0) begin
			q = QUAD_NE;
		end else if (x < 0 && y >= 0) begin
			q = QUAD_NW;
		end else if (x <= 0 && y < 0) begin
			q = QUAD_SW;
		end else if (x > 0 && y <= 0) begin
			q = QUAD_SE;
		end else begin
			q = QUAD_NONE;
		end
		return q;
	endfunction

	// Extremes crossed going counter-clockwise from quadrant j to quadrant k.
	// A quadrant is crossed when it lies at or after j and strictly before k.
	function automatic ext_t ext_of(quad_t j, quad_t k, logic long_way);
		logic [1:0] dist_k;
		ext_t       e;
		dist_k  = 2'(k - j);
		e.north = long_way || (2'(QUAD_NE - j) < dist_k);
		e.west  = long_way || (2'(QUAD_NW - j) < dist_k);
		e.south = long_way || (2'(QUAD_SW - j) < dist_k);
		e.east  = long_way || (2'(QUAD_SE - j) < dist_k);
		if (k == QUAD_NONE) begin
			e = '0;
		end
		return e;
	endfunction

endpackage

// ===== hdl/acbb_isqrt_stage.sv =====
// One registered stage of the pipelined square root, STEPS root bits per stage.
module acbb_isqrt_stage #(
	parameter int FIRST_STEP = 0,
	parameter int STEPS      = acbb_pkg::SQRT_STEPS_PER_STAGE
) (
	input  logic                  clk,
	input  logic                  en,
	input  acbb_pkg::sqrt_state_t sqrt_in,
	output acbb_pkg::sqrt_state_t sqrt_s
);
	import acbb_pkg::*;

	sqrt_state_t sqrt_next;

	// Restoring square root steps; the trial bit falls by two places each step.
	always_comb begin
		logic [SQ_W-1:0] rem;
		logic [SQ_W-1:0] root;
		logic [SQ_W-1:0] step_bit;
		logic [SQ_W:0]   trial;
		rem  = sqrt_in.rem;
		root = sqrt_in.root;
		for (int i = 0; i < STEPS; i++) begin
			step_bit = SQ_W'({1'b1, {(SQ_W - 2){1'b0}}} >> (2 * (FIRST_STEP + i)));
			trial    = {1'b0, root} + {1'b0, step_bit};
			if ({1'b0, rem} >= trial) begin
				rem  = rem - trial[SQ_W-1:0];
				root = (root >> 1) + step_bit;
			end else begin
				root = root >> 1;
			end
		end
		sqrt_next.rem  = rem;
		sqrt_next.root = root;
	end

	// Stage register; the enable comes from the pipeline's flow control.
	always_ff @(posedge clk) begin
		if (en) begin
			sqrt_s <= sqrt_next;
		end
	end

endmodule

// ===== hdl/arc_bounding_box_unit.sv =====
// Top level of the arc bounding box unit: an eight-stage pipeline.
//
// Each request carries an arc start point, the offset from the start to the
// circle centre and the offset from the centre to the end point. The unit
// returns the bounding box of the counter-clockwise arc in a frame with y
// pointing upwards. Both channels use a valid/ready handshake.
//
// Throughput: one request per cycle while the output is not stalled. The
// depth is set by the square root of the squared radius, which is worked
// out four root bits per stage over four stages.
//
// Reset clears every stage's valid bit; the unit is ready for requests
// straight after reset. When the receiver holds box_ready low, the box
// stays on the output and the stages behind it keep filling any empty
// slots, so req_ready falls only once every stage holds a request.
`include "assert_macros.svh"

module arc_bounding_box_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   req_valid,
	output logic                                   req_ready,
	input  logic signed [acbb_pkg::IN_W-1:0]       start_x,
	input  logic signed [acbb_pkg::IN_W-1:0]       start_y,
	input  logic signed [acbb_pkg::IN_W-1:0]       to_center_dx,
	input  logic signed [acbb_pkg::IN_W-1:0]       to_center_dy,
	input  logic signed [acbb_pkg::IN_W-1:0]       to_end_dx,
	input  logic signed [acbb_pkg::IN_W-1:0]       to_end_dy,
	output logic                                   box_valid,
	input  logic                                   box_ready,
	output logic signed [acbb_pkg::OUT_W-1:0]      box_xmin,
	output logic signed [acbb_pkg::OUT_W-1:0]      box_ymin,
	output logic signed [acbb_pkg::OUT_W-1:0]      box_xmax,
	output logic signed [acbb_pkg::OUT_W-1:0]      box_ymax
);
	import acbb_pkg::*;

	// Stage numbering: 1 and 2 prepare, then the square root, rounding, output.
	localparam int ST_SQRT0 = 3;
	localparam int ST_ROUND = ST_SQRT0 + SQRT_STAGES;
	localparam int N_ST     = ST_ROUND + 1;

	logic [1:N_ST] valid_s;
	logic [1:N_ST] stage_en;

	// Stage 1 registers.
	logic signed [COORD_W-1:0] x0_s1, y0_s1, x1_s1, y1_s1;
	logic signed [COORD_W-1:0] xc_s1;
	logic signed [COORD_W:0]   yc_s1;
	logic [SQ_W-2:0]           sqx_s1, sqy_s1;
	logic signed [SQ_W-1:0]    cra_s1, crb_s1;

	// Stage 2 onwards.
	side_t                     side_s [ST_SQRT0-1:ST_ROUND];
	logic [SQ_W-1:0]           sq_s2;
	sqrt_state_t               sqrt_s [0:SQRT_STAGES-1];
	logic [ROOT_W-1:0]         root_s7;

	// Flow control: a stage loads when it is empty or its contents move on.
	always_comb begin
		stage_en[N_ST] = !valid_s[N_ST] || box_ready;
		for (int i = N_ST - 1; i >= 1; i--) begin
			stage_en[i] = !valid_s[i] || stage_en[i + 1];
		end
	end

	assign req_ready = stage_en[1];
	assign box_valid = valid_s[N_ST];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (stage_en[1]) begin
				valid_s[1] <= req_valid;
			end
			for (int i = 2; i <= N_ST; i++) begin
				if (stage_en[i]) begin
					valid_s[i] <= valid_s[i - 1];
				end
			end
		end
	end

	// Stage 1: points relative to the centre, the centre itself and the products.
	logic signed [COORD_W-1:0]   x0_c, y0_c, x1_c, y1_c;
	logic signed [2*COORD_W-1:0] sqx_p, sqy_p, cra_p, crb_p;

	always_comb begin
		x0_c  = COORD_W'(0) - COORD_W'(to_center_dx);
		y0_c  = COORD_W'(to_center_dy);
		x1_c  = COORD_W'(to_end_dx);
		y1_c  = COORD_W'(0) - COORD_W'(to_end_dy);
		sqx_p = x0_c * x0_c;
		sqy_p = y0_c * y0_c;
		cra_p = y1_c * x0_c;
		crb_p = x1_c * y0_c;
	end

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			x0_s1  <= x0_c;
			y0_s1  <= y0_c;
			x1_s1  <= x1_c;
			y1_s1  <= y1_c;
			xc_s1  <= COORD_W'(start_x) + COORD_W'(to_center_dx);
			yc_s1  <= (COORD_W + 1)'(0)
				- ((COORD_W + 1)'(start_y) + (COORD_W + 1)'(to_center_dy));
			sqx_s1 <= sqx_p[SQ_W-2:0];
			sqy_s1 <= sqy_p[SQ_W-2:0];
			cra_s1 <= cra_p[SQ_W-1:0];
			crb_s1 <= crb_p[SQ_W-1:0];
		end
	end

	// Stage 2: squared radius, quadrants, crossed extremes and the endpoint box.
	quad_t quad_start, quad_end;
	side_t side_c;

	always_comb begin
		quad_start  = quad_of(x0_s1, y0_s1);
		quad_end    = quad_of(x1_s1, y1_s1);
		side_c.xc   = xc_s1;
		side_c.yc   = yc_s1;
		side_c.xmin = (x0_s1 < x1_s1) ? x0_s1 : x1_s1;
		side_c.xmax = (x0_s1 > x1_s1) ? x0_s1 : x1_s1;
		side_c.ymin = (y0_s1 < y1_s1) ? y0_s1 : y1_s1;
		side_c.ymax = (y0_s1 > y1_s1) ? y0_s1 : y1_s1;
		side_c.ext  = ext_of(quad_start, quad_end,
			(quad_start == quad_end) && (cra_s1 < crb_s1));
	end

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			sq_s2 <= SQ_W'(sqx_s1) + SQ_W'(sqy_s1);
		end
	end

	// Side data enters at stage 2 and follows the square root through the later stages.
	always_ff @(posedge clk) begin
		if (stage_en[ST_SQRT0 - 1]) begin
			side_s[ST_SQRT0 - 1] <= side_c;
		end
		for (int i = ST_SQRT0; i <= ST_ROUND; i++) begin
			if (stage_en[i]) begin
				side_s[i] <= side_s[i - 1];
			end
		end
	end

	// Square root stages.
	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
		sqrt_state_t sqrt_in;
		if (g == 0) begin : g_first
			assign sqrt_in = '{rem: sq_s2, root: '0};
		end else begin : g_next
			assign sqrt_in = sqrt_s[g - 1];
		end
		acbb_isqrt_stage #(
			.FIRST_STEP (g * SQRT_STEPS_PER_STAGE),
			.STEPS      (SQRT_STEPS_PER_STAGE)
		) u_stage (
			.clk     (clk),
			.en      (stage_en[ST_SQRT0 + g]),
			.sqrt_in (sqrt_in),
			.sqrt_s  (sqrt_s[g])
		);
	end

	// Rounding stage: step the root up when the remainder exceeds it.
	sqrt_state_t sqrt_last;
	assign sqrt_last = sqrt_s[SQRT_STAGES - 1];

	always_ff @(posedge clk) begin
		if (stage_en[ST_ROUND]) begin
			root_s7 <= ROOT_W'(sqrt_last.root)
				+ ROOT_W'(sqrt_last.rem > sqrt_last.root);
		end
	end

	// Output stage: widen the box by the crossed extremes and move it by the centre.
	side_t                     side_o;
	logic                      have_r;
	logic signed [OUT_W-1:0]   pos_r, neg_r;
	logic signed [OUT_W-1:0]   xmin_f, xmax_f, ymin_f, ymax_f;

	always_comb begin
		side_o = side_s[ST_ROUND];
		have_r = root_s7 != '0;
		pos_r  = signed'(OUT_W'(root_s7));
		neg_r  = OUT_W'(0) - pos_r;
		xmin_f = OUT_W'(side_o.xmin);
		xmax_f = OUT_W'(side_o.xmax);
		ymin_f = OUT_W'(side_o.ymin);
		ymax_f = OUT_W'(side_o.ymax);
		if (have_r && side_o.ext.west && xmin_f > neg_r) begin
			xmin_f = neg_r;
		end
		if (have_r && side_o.ext.east && xmax_f < pos_r) begin
			xmax_f = pos_r;
		end
		if (have_r && side_o.ext.south && ymin_f > neg_r) begin
			ymin_f = neg_r;
		end
		if (have_r && side_o.ext.north && ymax_f < pos_r) begin
			ymax_f = pos_r;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[N_ST]) begin
			box_xmin <= OUT_W'(xmin_f + OUT_W'(side_o.xc));
			box_xmax <= OUT_W'(xmax_f + OUT_W'(side_o.xc));
			box_ymin <= OUT_W'(ymin_f + OUT_W'(side_o.yc));
			box_ymax <= OUT_W'(ymax_f + OUT_W'(side_o.yc));
		end
	end

	// A valid box is never inverted on either axis.
	`ASSERT_IMPLIES(a_box_ordered, clk, arst_n, box_valid, (box_xmin <= box_xmax) && (box_ymin <= box_ymax))
	// With no box waiting at the output, every stage can move and req_ready is high.
	`ASSERT_IMPLIES(a_ready_when_drained, clk, arst_n, !box_valid, req_ready)
	// A request held in the rounding stage during a stall is not dropped.
	`ASSERT_NEXT(a_round_kept, clk, arst_n, valid_s[ST_ROUND] && !stage_en[ST_ROUND], valid_s[ST_ROUND])

endmodule
